FILE: hdl/v3n_pkg.sv
// v3n_pkg: shared types and constants for the vector3_normalize block.
// Used by the sqrt cell, divide cell and top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package v3n_pkg;
   localparam int CompW   = 32;
   localparam int SumW    = 64;
   localparam int RootW   = 32;
   localparam int NumW    = 48;
   localparam int ThreshW = 16;
   localparam int SqrtSteps = 32;
   localparam int DivSteps  = 48;

   localparam logic [0:0] RegZeroThreshold = 1'b0;

   // Payload carried alongside the arithmetic through every cell.
   typedef struct packed {
      logic [CompW-1:0] x;
      logic [CompW-1:0] y;
      logic [CompW-1:0] z;
      logic [2:0]       neg;
      logic [CompW-1:0] ax;
      logic [CompW-1:0] ay;
      logic [CompW-1:0] az;
      logic [ThreshW-1:0] thr;
   } vec_type;

   typedef struct packed {
      logic [SumW-1:0]  rem;
      logic [RootW-1:0] root;
   } sqrt_type;

   typedef struct packed {
      logic [NumW-1:0]   nx;
      logic [NumW-1:0]   ny;
      logic [NumW-1:0]   nz;
      logic [RootW:0]    rx;
      logic [RootW:0]    ry;
      logic [RootW:0]    rz;
      logic [RootW-1:0]  mag;
   } div_type;
endpackage
`default_nettype wire

FILE: hdl/v3n_sqrt_cell.sv
// v3n_sqrt_cell: one restoring square-root step, one root bit per cell.
// Depends on v3n_pkg.
`timescale 1ns / 1ps
`default_nettype none
module v3n_sqrt_cell (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              enable,
   input  wire logic [5:0]        step,
   input  wire logic              valid_in,
   input  wire v3n_pkg::sqrt_type sq_in,
   input  wire v3n_pkg::vec_type  vec_in,
   output logic                   valid_out,
   output v3n_pkg::sqrt_type      sq_out,
   output v3n_pkg::vec_type       vec_out
);
   logic                valid_ff;
   v3n_pkg::sqrt_type   sq_ff, sq_in_d;
   v3n_pkg::vec_type    vec_ff;
   logic [v3n_pkg::SumW-1:0] trial, top;

   // Remainder compared with (4*root+1) placed at bit 2*step.
   always_comb begin
      top   = sq_in.rem >> {step, 1'b0};
      trial = {30'd0, sq_in.root, 2'b01};
      sq_in_d.root = {sq_in.root[v3n_pkg::RootW-2:0], 1'b0};
      sq_in_d.rem  = sq_in.rem;
      if (top >= trial) begin
         sq_in_d.root = {sq_in.root[v3n_pkg::RootW-2:0], 1'b1};
         sq_in_d.rem  = sq_in.rem - (trial << {step, 1'b0});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
      if (enable) begin
         sq_ff  <= sq_in_d;
         vec_ff <= vec_in;
      end
   end
   assign valid_out = valid_ff;
   assign sq_out    = sq_ff;
   assign vec_out   = vec_ff;
endmodule
`default_nettype wire

FILE: hdl/v3n_div_cell.sv
// v3n_div_cell: one restoring division step for all three components.
// Depends on v3n_pkg.
`timescale 1ns / 1ps
`default_nettype none
module v3n_div_cell (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             enable,
   input  wire logic             valid_in,
   input  wire v3n_pkg::div_type dv_in,
   input  wire v3n_pkg::vec_type vec_in,
   output logic                  valid_out,
   output v3n_pkg::div_type      dv_out,
   output v3n_pkg::vec_type      vec_out
);
   logic             valid_ff;
   v3n_pkg::div_type dv_ff, dv_d;
   v3n_pkg::vec_type vec_ff;
   logic [v3n_pkg::RootW:0] sx, sy, sz, d;

   always_comb begin
      d  = {1'b0, dv_in.mag};
      sx = {dv_in.rx[v3n_pkg::RootW-1:0], dv_in.nx[v3n_pkg::NumW-1]};
      sy = {dv_in.ry[v3n_pkg::RootW-1:0], dv_in.ny[v3n_pkg::NumW-1]};
      sz = {dv_in.rz[v3n_pkg::RootW-1:0], dv_in.nz[v3n_pkg::NumW-1]};
      dv_d.mag = dv_in.mag;
      dv_d.nx = {dv_in.nx[v3n_pkg::NumW-2:0], (sx >= d)};
      dv_d.ny = {dv_in.ny[v3n_pkg::NumW-2:0], (sy >= d)};
      dv_d.nz = {dv_in.nz[v3n_pkg::NumW-2:0], (sz >= d)};
      dv_d.rx = (sx >= d) ? sx - d : sx;
      dv_d.ry = (sy >= d) ? sy - d : sy;
      dv_d.rz = (sz >= d) ? sz - d : sz;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
      if (enable) begin
         dv_ff  <= dv_d;
         vec_ff <= vec_in;
      end
   end
   assign valid_out = valid_ff;
   assign dv_out    = dv_ff;
   assign vec_out   = vec_ff;
endmodule
`default_nettype wire

FILE: hdl/vector3_normalize.sv
// vector3_normalize: top level, a 3D vector normalizer in Q16.16.
// Depends on v3n_pkg, v3n_sqrt_cell and v3n_div_cell.
//
//   channel   dir  payload
//   req_      in   tdata {z_in, y_in, x_in}, 96 bits
//   rsp_      out  tdata {magnitude, z_out, y_out, x_out}, tuser unchanged
//   csr_      in   APB, register 0 zero_threshold at byte address 0
//
// One transaction is accepted per cycle while not stalled. Stages: one input
// stage, one squaring stage, a chain of 32 square-root cells (one root bit
// each), a chain of 48 divide cells (one quotient bit each, three components
// side by side) and the output register. The whole chain advances when the
// output register is empty or being taken, so a stalled result holds it.
// Synchronous reset empties every stage and sets zero_threshold to 1.
`timescale 1ns / 1ps
`default_nettype none
module vector3_normalize (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [95:0]  req_tdata,   // x_in, y_in, z_in
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [127:0]      rsp_tdata,   // x_out, y_out, z_out, magnitude
   output logic              rsp_tuser,   // unchanged
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [2:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);
   localparam int SQ = v3n_pkg::SqrtSteps;
   localparam int DV = v3n_pkg::DivSteps;

   logic [v3n_pkg::ThreshW-1:0] thr_ff;
   logic enable;

   // Configuration register.
   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= v3n_pkg::ThreshW'(1);
      end else if (csr_psel && csr_penable && csr_pwrite
                   && csr_paddr[2] == v3n_pkg::RegZeroThreshold) begin
         thr_ff <= csr_pwdata[v3n_pkg::ThreshW-1:0];
      end
   end
   assign csr_prdata = (csr_paddr[2] == v3n_pkg::RegZeroThreshold) ?
                       {16'd0, thr_ff} : 32'd0;

   // The output register parts the chain from the result side.
   logic out_valid_ff;
   assign enable     = !out_valid_ff || rsp_tready;
   assign req_tready = enable;

   // Input stage: capture and take absolute values.
   logic v0_ff;
   v3n_pkg::vec_type vec0_ff;
   function automatic logic [31:0] abs32(input logic [31:0] a);
      abs32 = a[31] ? (~a + 32'd1) : a;
   endfunction
   always_ff @(posedge clock) begin
      if (reset) v0_ff <= 1'b0;
      else if (enable) v0_ff <= req_tvalid;
      if (enable) begin
         vec0_ff.x   <= req_tdata[31:0];
         vec0_ff.y   <= req_tdata[63:32];
         vec0_ff.z   <= req_tdata[95:64];
         vec0_ff.neg <= {req_tdata[95], req_tdata[63], req_tdata[31]};
         vec0_ff.ax  <= abs32(req_tdata[31:0]);
         vec0_ff.ay  <= abs32(req_tdata[63:32]);
         vec0_ff.az  <= abs32(req_tdata[95:64]);
         vec0_ff.thr <= thr_ff;
      end
   end

   // Squaring stage: three 32x32 products summed.
   logic v1_ff;
   v3n_pkg::vec_type  vec1_ff;
   v3n_pkg::sqrt_type sq1;
   logic [63:0] sum_ff;
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (enable) v1_ff <= v0_ff;
      if (enable) begin
         vec1_ff <= vec0_ff;
         sum_ff  <= 64'(vec0_ff.ax) * 64'(vec0_ff.ax)
                  + 64'(vec0_ff.ay) * 64'(vec0_ff.ay)
                  + 64'(vec0_ff.az) * 64'(vec0_ff.az);
      end
   end
   assign sq1.rem  = sum_ff;
   assign sq1.root = '0;

   // Square-root chain, most significant root bit first.
   logic              sv [SQ+1];
   v3n_pkg::sqrt_type ss [SQ+1];
   v3n_pkg::vec_type  sx [SQ+1];
   assign sv[0] = v1_ff;
   assign ss[0] = sq1;
   assign sx[0] = vec1_ff;
   for (genvar i = 0; i < SQ; i++) begin : g_sqrt
      v3n_sqrt_cell u_cell (
         .clock(clock), .reset(reset), .enable(enable),
         .step(6'(SQ-1-i)),
         .valid_in(sv[i]), .sq_in(ss[i]), .vec_in(sx[i]),
         .valid_out(sv[i+1]), .sq_out(ss[i+1]), .vec_out(sx[i+1]));
   end

   // Divide chain: dividend is |c| shifted left by 16 bits.
   logic             dvv [DV+1];
   v3n_pkg::div_type dd  [DV+1];
   v3n_pkg::vec_type dx  [DV+1];
   assign dvv[0]   = sv[SQ];
   assign dx[0]    = sx[SQ];
   assign dd[0].nx = {sx[SQ].ax, 16'd0};
   assign dd[0].ny = {sx[SQ].ay, 16'd0};
   assign dd[0].nz = {sx[SQ].az, 16'd0};
   assign dd[0].rx = '0;
   assign dd[0].ry = '0;
   assign dd[0].rz = '0;
   assign dd[0].mag = ss[SQ].root;
   for (genvar j = 0; j < DV; j++) begin : g_div
      v3n_div_cell u_cell (
         .clock(clock), .reset(reset), .enable(enable),
         .valid_in(dvv[j]), .dv_in(dd[j]), .vec_in(dx[j]),
         .valid_out(dvv[j+1]), .dv_out(dd[j+1]), .vec_out(dx[j+1]));
   end

   // Output register: choose normalized or unchanged vector.
   v3n_pkg::div_type dl;
   v3n_pkg::vec_type vl;
   logic pass;
   logic [31:0] qx, qy, qz;
   assign dl = dd[DV];
   assign vl = dx[DV];
   assign pass = (dl.mag == '0) || (dl.mag < {16'd0, vl.thr});
   assign qx = vl.neg[0] ? ~dl.nx[31:0] + 32'd1 : dl.nx[31:0];
   assign qy = vl.neg[1] ? ~dl.ny[31:0] + 32'd1 : dl.ny[31:0];
   assign qz = vl.neg[2] ? ~dl.nz[31:0] + 32'd1 : dl.nz[31:0];

   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else if (enable) out_valid_ff <= dvv[DV];
      if (enable) begin
         rsp_tdata <= pass ? {dl.mag, vl.z, vl.y, vl.x} : {dl.mag, qz, qy, qx};
         rsp_tuser <= pass;
      end
   end
   assign rsp_tvalid = out_valid_ff;
endmodule
`default_nettype wire

FILE: hdl/v3n_checker.sv
// v3n_checker: port-level assertions for vector3_normalize, bound to the top.
// Depends on vector3_normalize ports only.
`timescale 1ns / 1ps
`default_nettype none
module v3n_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tready,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [127:0] rsp_tdata,
   input wire logic         rsp_tuser,
   input wire logic         csr_pready
);
   // A stalled result holds its payload.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");
   // The input side stalls only while a result is waiting.
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled without output backpressure");
   // A zero magnitude always passes the vector through.
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[127:96] == 32'd0 |-> rsp_tuser)
      else $error("zero magnitude not flagged");
   a_pready: assert property (@(posedge clock) csr_pready)
      else $error("pready low");
endmodule

bind vector3_normalize v3n_checker u_v3n_checker (
   .clock(clock), .reset(reset), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .csr_pready(csr_pready));
`default_nettype wire

FILE: verif/tb_vector3_normalize.sv
// tb_vector3_normalize: self-checking testbench for the vector3_normalize block.
// Depends on v3n_pkg and the vector3_normalize RTL; needs no files or arguments.
`timescale 1ns / 1ps
`default_nettype none
module tb_vector3_normalize;

   // One expected result: components, magnitude and the pass-through flag.
   typedef struct {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic [31:0] mag;
      logic        unchanged;
   } norm_result_type;

   // One directed row: the vector, an optional threshold write first, and
   // an optional hand-typed expectation.
   typedef struct {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      bit          set_thr;
      logic [15:0] thr;
      bit          typed;
      logic [31:0] ex;
      logic [31:0] ey;
      logic [31:0] ez;
      logic [31:0] emag;
      logic        eunch;
   } vec_row_type;

   localparam int Latency  = 83;
   localparam int WatchMax = 20000;
   localparam int NumRandom = 1550;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [95:0] req_tdata = '0;   // x_in, y_in, z_in
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;       // x_out, y_out, z_out, magnitude
   logic rsp_tuser;               // unchanged
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [2:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   vector3_normalize DUT (.*);

   // The testbench's own copy of the threshold register.
   logic [15:0] thr_shadow = 16'd1;
   norm_result_type pending_results[$];
   int errors = 0;
   int idle_cycles = 0;
   bit calm_phase = 1'b0;     // last part of the run: no idling on either side
   bit hold_off = 1'b0;       // long receiver stall requested by the sender side

   initial begin
      forever #1 clock = ~clock;
   end

   // Exact floor square root of a 64-bit sum, one root bit per iteration.
   function automatic logic [31:0] floor_sqrt(logic [63:0] v);
      logic [63:0] rem;
      logic [63:0] root;
      logic [63:0] bitv;
      rem = v;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > rem && bitv != 0) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (rem >= root + bitv) begin
            rem = rem - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root[31:0];
   endfunction

   // Predicts the normalized vector for one input under the current threshold.
   function automatic norm_result_type normalize_vector(logic [31:0] x, logic [31:0] y,
                                                        logic [31:0] z);
      norm_result_type r;
      logic [31:0] comp[3];
      logic [32:0] mabs[3];
      logic [63:0] sum;
      logic [31:0] mag;
      logic [47:0] q;
      comp[0] = x;
      comp[1] = y;
      comp[2] = z;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
         mabs[i] = comp[i][31] ? (33'h1_0000_0000 - {1'b0, comp[i]}) : {1'b0, comp[i]};
         sum = sum + 64'(mabs[i]) * 64'(mabs[i]);
      end
      mag = floor_sqrt(sum);
      r.mag = mag;
      if (mag == 0 || mag < {16'd0, thr_shadow}) begin
         r.x = x;
         r.y = y;
         r.z = z;
         r.unchanged = 1'b1;
      end else begin
         for (int i = 0; i < 3; i++) begin
            q = (48'(mabs[i]) << 16) / 48'(mag);
            comp[i] = comp[i][31] ? (32'd0 - q[31:0]) : q[31:0];
         end
         r.x = comp[0];
         r.y = comp[1];
         r.z = comp[2];
         r.unchanged = 1'b0;
      end
      return r;
   endfunction

   // Watchdog: counts cycles without any accepted transaction.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchMax) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Result checker: each accepted transaction is matched with the oldest
   // expectation, field by field.
   always @(posedge clock) begin
      norm_result_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result transaction %h", rsp_tdata);
            errors++;
         end else begin
            e = pending_results.pop_front();
            if (rsp_tdata[31:0] !== e.x) begin
               $error("x_out expected %h actual %h", e.x, rsp_tdata[31:0]);
               errors++;
            end
            if (rsp_tdata[63:32] !== e.y) begin
               $error("y_out expected %h actual %h", e.y, rsp_tdata[63:32]);
               errors++;
            end
            if (rsp_tdata[95:64] !== e.z) begin
               $error("z_out expected %h actual %h", e.z, rsp_tdata[95:64]);
               errors++;
            end
            if (rsp_tdata[127:96] !== e.mag) begin
               $error("magnitude expected %h actual %h", e.mag, rsp_tdata[127:96]);
               errors++;
            end
            if (rsp_tuser !== e.unchanged) begin
               $error("unchanged expected %b actual %b", e.unchanged, rsp_tuser);
               errors++;
            end
         end
      end
   end

   // Receiver: random stall bursts, a long hold-off on request, none at the end.
   initial begin
      int n;
      bit held;
      held = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off && !held) begin
            rsp_tready <= 1'b0;
            // Long enough that the whole pipeline fills and stalls the input.
            for (int i = 0; i < 300; i++) @(negedge clock);
            held = 1'b1;
         end else if (!calm_phase && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
            n = $urandom_range(1, 20);
            for (int i = 0; i < n && !(hold_off && !held); i++) @(negedge clock);
         end
      end
   end

   // APB write, setup then access phase; the shadow copy follows the block's register.
   task automatic write_threshold(logic [31:0] value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= {v3n_pkg::RegZeroThreshold, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      thr_shadow = value[15:0];
   endtask

   // Waits until every expected result has come, plus the pipeline depth.
   task automatic drain_pipeline();
      while (pending_results.size() != 0) @(negedge clock);
      for (int i = 0; i < Latency + 4; i++) @(negedge clock);
   endtask

   // Offers one vector and waits for its handshake; queues its expectation.
   task automatic send_vector(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                              bit gaps);
      int n;
      if (gaps && !calm_phase && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         n = $urandom_range(1, 8);
         for (int i = 0; i < n; i++) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {z, y, x};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_results.push_back(normalize_vector(x, y, z));
      @(negedge clock);
   endtask

   // Random component: often full-range, often small, some extremes.
   function automatic logic [31:0] random_comp();
      unique case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2, 3: return 32'($signed($urandom_range(0, 8)) - 4);
         4, 5: return 32'($signed($urandom_range(0, 262144)) - 131072);
         default: return $urandom;
      endcase
   endfunction

   vec_row_type directed[$];

   initial begin
      vec_row_type row;
      logic [15:0] thr_plan[5];
      thr_plan = '{16'd0, 16'hFFFF, 16'd1, 16'd300, 16'h8000};

      // Directed rows. Typed expectations come straight from the definition;
      // the others rely on the predictor.
      // Zero vector with reset threshold: passes through, magnitude 0.
      directed.push_back('{0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 1});
      // Unit x: magnitude 1.0, result is exactly 1.0 on x.
      directed.push_back('{32'h10000, 0, 0, 0, 0, 1, 32'h10000, 0, 0, 32'h10000, 0});
      // Negative unit z.
      directed.push_back('{0, 0, 32'hFFFF0000, 0, 0, 1, 0, 0, 32'hFFFF0000, 32'h10000, 0});
      // Smallest step on y: magnitude one LSB, still at the reset threshold.
      directed.push_back('{0, 1, 0, 0, 0, 1, 0, 32'h10000, 0, 1, 0});
      // Threshold zero: a zero vector must still pass through.
      directed.push_back('{0, 0, 0, 1, 16'd0, 1, 0, 0, 0, 0, 1});
      directed.push_back('{0, 0, 32'hFFFFFFFF, 0, 0, 1, 0, 0, 32'hFFFF0000, 1, 0});
      // Most negative on all three: largest magnitude.
      directed.push_back('{32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0, 0, 0, 0, 0, 0});
      directed.push_back('{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, 0, 0, 0, 0, 0, 0});
      directed.push_back('{32'h80000000, 0, 0, 0, 0, 1, 32'hFFFF0000, 0, 0, 32'h80000000, 0});
      directed.push_back('{32'h7FFFFFFF, 32'h80000000, 32'h12345678, 0, 0, 0, 0, 0, 0, 0, 0});
      // Largest threshold: a vector just below passes through, one at it does not.
      directed.push_back('{32'h0000FFFE, 0, 0, 1, 16'hFFFF, 1,
                           32'h0000FFFE, 0, 0, 32'h0000FFFE, 1});
      directed.push_back('{0, 32'h0000FFFF, 0, 0, 0, 1, 0, 32'h10000, 0, 32'h0000FFFF, 0});
      directed.push_back('{3, 4, 0, 0, 0, 1, 3, 4, 0, 5, 1});
      directed.push_back('{32'hFFFD0000, 32'h00040000, 0, 0, 0, 0, 0, 0, 0, 0, 0});
      directed.push_back('{32'h00010000, 32'h00010000, 32'h00010000, 1, 16'd1,
                           0, 0, 0, 0, 0, 0});
      directed.push_back('{3, 4, 0, 0, 0, 1, 32'h9999, 32'hCCCC, 0, 5, 0});
      directed.push_back('{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0, 0, 0, 0, 0, 0, 0});
      directed.push_back('{32'h55555555, 32'hAAAAAAAA, 32'h0F0F0F0F, 0, 0, 0, 0, 0, 0, 0, 0});

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed[i]) begin
         row = directed[i];
         if (row.set_thr) begin
            req_tvalid <= 1'b0;
            drain_pipeline();
            // Upper bits set too: the register keeps only its low 16 bits.
            write_threshold({16'hA5A5, row.thr});
         end
         send_vector(row.x, row.y, row.z, 1'b0);
         if (row.typed) begin
            pending_results[$].x = row.ex;
            pending_results[$].y = row.ey;
            pending_results[$].z = row.ez;
            pending_results[$].mag = row.emag;
            pending_results[$].unchanged = row.eunch;
         end
      end

      // Random part in phases, each under its own threshold.
      for (int p = 0; p < 5; p++) begin
         req_tvalid <= 1'b0;
         drain_pipeline();
         write_threshold(p == 3 ? $urandom : {16'd0, thr_plan[p]});
         if (p == 2) hold_off = 1'b1;
         if (p == 4) calm_phase = 1'b1;
         for (int k = 0; k < NumRandom / 5; k++)
            send_vector(random_comp(), random_comp(), random_comp(), 1'b1);
      end
      req_tvalid <= 1'b0;

      while (pending_results.size() != 0) @(negedge clock);
      for (int i = 0; i < Latency + 4; i++) @(negedge clock);
      if (errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
`default_nettype wire

FILE: vector3_normalize.f
hdl/v3n_pkg.sv
hdl/v3n_sqrt_cell.sv
hdl/v3n_div_cell.sv
hdl/vector3_normalize.sv
hdl/v3n_checker.sv
verif/tb_vector3_normalize.sv
